/* hw/rtl/pccfe_pkg.sv */
// Shared types, constants and helper functions of the point crop and feature encoder.
`timescale 1ns / 1ps

package pccfe_pkg;

  localparam int COUNT_WIDTH = 32;
  localparam int QDEPTH      = 4;
  localparam int QPTR_W      = $clog2(QDEPTH);
  localparam int QCNT_W      = $clog2(QDEPTH + 1);

  typedef enum logic [2:0] {
    CFG_X_WINDOW        = 3'd0,
    CFG_Y_WINDOW        = 3'd1,
    CFG_Z_WINDOW        = 3'd2,
    CFG_INTENSITY_FLOOR = 3'd3,
    CFG_INTENSITY_RECIP = 3'd4,
    CFG_FEATURE_MODE    = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic [47:0] x_window;
    logic [47:0] y_window;
    logic [47:0] z_window;
    logic [15:0] intensity_floor;
    logic [31:0] intensity_recip;
    logic [1:0]  feature_mode;
  } cfg_t;

  typedef struct packed {
    logic               frame_start;
    logic               point_valid;
    logic               core_finite;
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic signed [23:0] pos_z;
    logic signed [15:0] intensity;
    logic signed [15:0] elongation;
    logic               elongation_finite;
    logic signed [15:0] radial_velocity;
    logic               velocity_finite;
  } in_item_t;

  typedef struct packed {
    logic               kept;
    logic signed [23:0] feat_x;
    logic signed [23:0] feat_y;
    logic signed [23:0] feat_z;
    logic signed [15:0] feat_intensity;
    logic signed [15:0] feat_fifth;
    logic [31:0]        invalid_total;
    logic [31:0]        outside_total;
    logic [31:0]        seen_total;
  } out_item_t;

  // classified point handed from the front end to the back end
  typedef struct packed {
    logic               kept;
    logic               raw_mode;
    logic [15:0]        delta;      // intensity above floor, 0 when not above
    logic signed [15:0] raw_intensity;
    logic signed [15:0] fifth;
    logic signed [23:0] x;
    logic signed [23:0] y;
    logic signed [23:0] z;
    logic [31:0]        invalid_total;
    logic [31:0]        outside_total;
    logic [31:0]        seen_total;
  } task_t;

  function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] c);
    return (c == '1) ? c : c + COUNT_WIDTH'(1);
  endfunction

  function automatic logic [31:0] total32(input logic [COUNT_WIDTH-1:0] c);
    logic [63:0] w;
    w = 64'(c);
    return (w > 64'h0000_0000_FFFF_FFFF) ? 32'hFFFF_FFFF : w[31:0];
  endfunction

  function automatic logic in_window(input logic [47:0] win, input logic signed [23:0] p);
    logic signed [23:0] lo;
    logic signed [23:0] hi;
    lo = $signed(win[23:0]);
    hi = $signed(win[47:24]);
    return (p >= lo) && (p < hi);
  endfunction

endpackage

/* hw/rtl/point_cloud_crop_feature_encoder.sv */
// Top level of the point crop and feature encoder: config registers and the two halves.
// Path: a point accepted at a clock edge is written to the task queue, then passes the
//   multiply stage and the result register before it shows on the result ports.
// Throughput: one point per cycle while full is low and results are popped; the four-entry
//   task queue and the result register let input and output stall independently.
// Reset (synchronous, rst_n low): config registers and frame counters clear to zero,
//   queue and pipeline empty; no clearing pass.
`timescale 1ns / 1ps

module point_cloud_crop_feature_encoder (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  output logic                  full,
  input  pccfe_pkg::in_item_t   in_item,
  output logic                  empty,
  input  logic                  pop,
  output pccfe_pkg::out_item_t  out_item,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [2:0]            cfg_index,
  input  logic [47:0]           cfg_data
);

  pccfe_pkg::cfg_t  cfg_r;
  pccfe_pkg::task_t front_task, q_data;
  logic             accept, q_empty, q_rd;

  assign cfg_ready = 1'b1;
  assign accept    = push && !full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        pccfe_pkg::CFG_X_WINDOW:        cfg_r.x_window        <= cfg_data;
        pccfe_pkg::CFG_Y_WINDOW:        cfg_r.y_window        <= cfg_data;
        pccfe_pkg::CFG_Z_WINDOW:        cfg_r.z_window        <= cfg_data;
        pccfe_pkg::CFG_INTENSITY_FLOOR: cfg_r.intensity_floor <= cfg_data[15:0];
        pccfe_pkg::CFG_INTENSITY_RECIP: cfg_r.intensity_recip <= cfg_data[31:0];
        pccfe_pkg::CFG_FEATURE_MODE:    cfg_r.feature_mode    <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  pccfe_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg_r),
    .accept (accept),
    .item   (in_item),
    .task_o (front_task)
  );

  pccfe_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (accept),
    .wr_data (front_task),
    .full    (full),
    .rd      (q_rd),
    .rd_data (q_data),
    .empty   (q_empty)
  );

  pccfe_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .q_empty  (q_empty),
    .q_data   (q_data),
    .q_rd     (q_rd),
    .empty    (empty),
    .pop      (pop),
    .out_item (out_item)
  );

endmodule

/* hw/rtl/pccfe_front.sv */
// Front end: classifies each accepted point, keeps the frame counters, builds a task.
`timescale 1ns / 1ps

module pccfe_front (
  input  logic              clk,
  input  logic              rst_n,
  input  pccfe_pkg::cfg_t   cfg,
  input  logic              accept,
  input  pccfe_pkg::in_item_t item,
  output pccfe_pkg::task_t  task_o
);

  logic [pccfe_pkg::COUNT_WIDTH-1:0] invalid_r, invalid_nxt;
  logic [pccfe_pkg::COUNT_WIDTH-1:0] outside_r, outside_nxt;
  logic [pccfe_pkg::COUNT_WIDTH-1:0] seen_r, seen_nxt;
  logic [pccfe_pkg::COUNT_WIDTH-1:0] inv_base, out_base, seen_base;
  logic                              is_invalid, is_inside, keep, raw_mode;
  logic signed [16:0]                diff;

  always_comb begin
    inv_base  = item.frame_start ? '0 : invalid_r;
    out_base  = item.frame_start ? '0 : outside_r;
    seen_base = item.frame_start ? '0 : seen_r;

    is_invalid = !item.point_valid || !item.core_finite;
    is_inside  = pccfe_pkg::in_window(cfg.x_window, item.pos_x) &&
                 pccfe_pkg::in_window(cfg.y_window, item.pos_y) &&
                 pccfe_pkg::in_window(cfg.z_window, item.pos_z);
    keep       = !is_invalid && is_inside;
    raw_mode   = cfg.feature_mode[1];

    seen_nxt    = pccfe_pkg::sat_inc(seen_base);
    invalid_nxt = is_invalid ? pccfe_pkg::sat_inc(inv_base) : inv_base;
    outside_nxt = (!is_invalid && !is_inside) ? pccfe_pkg::sat_inc(out_base) : out_base;

    diff = 17'(item.intensity) - 17'($signed(cfg.intensity_floor));

    task_o.kept          = keep;
    task_o.raw_mode      = raw_mode;
    task_o.delta         = (diff > 17'sd0) ? diff[15:0] : 16'd0;
    task_o.raw_intensity = item.intensity;
    if (!keep)
      task_o.fifth = '0;
    else if (raw_mode && item.elongation_finite)
      task_o.fifth = item.elongation;
    else if (cfg.feature_mode[0] && item.velocity_finite)
      task_o.fifth = item.radial_velocity;
    else
      task_o.fifth = '0;
    task_o.x             = keep ? item.pos_x : '0;
    task_o.y             = keep ? item.pos_y : '0;
    task_o.z             = keep ? item.pos_z : '0;
    task_o.invalid_total = pccfe_pkg::total32(invalid_nxt);
    task_o.outside_total = pccfe_pkg::total32(outside_nxt);
    task_o.seen_total    = pccfe_pkg::total32(seen_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      invalid_r <= '0;
      outside_r <= '0;
      seen_r    <= '0;
    end else if (accept) begin
      invalid_r <= invalid_nxt;
      outside_r <= outside_nxt;
      seen_r    <= seen_nxt;
    end
  end

  a_seen_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> seen_r != '0)
    else $error("seen counter zero after an accepted item");

endmodule

/* hw/rtl/pccfe_queue.sv */
// Short task queue between the front end and the back end.
`timescale 1ns / 1ps

module pccfe_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr,
  input  pccfe_pkg::task_t wr_data,
  output logic             full,
  input  logic             rd,
  output pccfe_pkg::task_t rd_data,
  output logic             empty
);

  pccfe_pkg::task_t               mem [pccfe_pkg::QDEPTH];
  logic [pccfe_pkg::QPTR_W-1:0]   wptr_r, rptr_r;
  logic [pccfe_pkg::QCNT_W-1:0]   count_r;
  logic                           do_wr, do_rd;

  localparam logic [pccfe_pkg::QPTR_W-1:0] LAST = pccfe_pkg::QPTR_W'(pccfe_pkg::QDEPTH - 1);
  localparam logic [pccfe_pkg::QCNT_W-1:0] CAP  = pccfe_pkg::QCNT_W'(pccfe_pkg::QDEPTH);

  assign full    = (count_r == CAP);
  assign empty   = (count_r == '0);
  assign do_wr   = wr && !full;
  assign do_rd   = rd && !empty;
  assign rd_data = mem[rptr_r];

  always_ff @(posedge clk) begin
    if (do_wr) mem[wptr_r] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      if (do_wr) wptr_r <= (wptr_r == LAST) ? '0 : wptr_r + 1'b1;
      if (do_rd) rptr_r <= (rptr_r == LAST) ? '0 : rptr_r + 1'b1;
      case ({do_wr, do_rd})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CAP)
    else $error("queue count above depth");

  a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
    (do_wr && !do_rd) |=> count_r == $past(count_r) + 1'b1)
    else $error("queue count did not grow on write");

endmodule

/* hw/rtl/pccfe_back.sv */
// Back end: intensity scaling multiply, saturation and the result register.
`timescale 1ns / 1ps

module pccfe_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  pccfe_pkg::cfg_t       cfg,
  input  logic                  q_empty,
  input  pccfe_pkg::task_t      q_data,
  output logic                  q_rd,
  output logic                  empty,
  input  logic                  pop,
  output pccfe_pkg::out_item_t  out_item
);

  pccfe_pkg::task_t     s1_r;
  logic                 s1_v_r;
  logic [47:0]          prod_r;
  pccfe_pkg::out_item_t out_r, out_nxt;
  logic                 outv_r;
  logic                 adv_out, adv_s1;
  logic [15:0]          norm;

  assign adv_out = !outv_r || pop;
  assign adv_s1  = !s1_v_r || adv_out;
  assign q_rd    = adv_s1 && !q_empty;

  // product is d * recip; a kept point's scaled-mode intensity feature is product >> 16 capped at 32767
  always_comb begin
    norm = (prod_r[47:31] != '0) ? 16'h7FFF : {1'b0, prod_r[30:16]};
    out_nxt.kept           = s1_r.kept;
    out_nxt.feat_x         = s1_r.x;
    out_nxt.feat_y         = s1_r.y;
    out_nxt.feat_z         = s1_r.z;
    out_nxt.feat_intensity = !s1_r.kept ? 16'sd0 :
                             s1_r.raw_mode ? s1_r.raw_intensity : $signed(norm);
    out_nxt.feat_fifth     = s1_r.fifth;
    out_nxt.invalid_total  = s1_r.invalid_total;
    out_nxt.outside_total  = s1_r.outside_total;
    out_nxt.seen_total     = s1_r.seen_total;
  end

  always_ff @(posedge clk) begin
    if (adv_s1 && !q_empty) begin
      s1_r   <= q_data;
      prod_r <= 48'(q_data.delta) * 48'(cfg.intensity_recip);
    end
    if (adv_out && s1_v_r) out_r <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      outv_r <= 1'b0;
    end else begin
      if (adv_s1) s1_v_r <= !q_empty;
      if (adv_out) outv_r <= s1_v_r;
    end
  end

  assign empty    = !outv_r;
  assign out_item = out_r;

  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && outv_r && !pop) |=> s1_v_r && $stable(s1_r))
    else $error("multiply stage changed while result stalled");

  a_drop_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (outv_r && !out_r.kept) |-> (out_r.feat_intensity == 16'sd0 && out_r.feat_fifth == 16'sd0))
    else $error("discarded item carries nonzero features");

endmodule

/* dv/tb_top.sv */
// Self-checking testbench for the point crop and feature encoder.
`timescale 1ns / 1ps

module tb_top;
  import pccfe_pkg::*;

  localparam int LATENCY     = 2;
  localparam int RAND_POINTS = 1800;
  localparam int CYCLE_LIMIT = 1_000_000;
  // index outside the register map; a write there must change nothing
  localparam logic [2:0] CFG_IDX_UNUSED = 3'd7;

  typedef struct {
    bit          is_write;
    logic [2:0]  idx;
    logic [47:0] data;
    in_item_t    pt;
    bit          typed;
    out_item_t   res;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        push = 1'b0;
  logic        full;
  in_item_t    in_item = '0;
  logic        empty;
  logic        pop = 1'b0;
  out_item_t   out_item;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [47:0] cfg_data = '0;

  // predictor state
  cfg_t                   enc_cfg = '0;
  logic [COUNT_WIDTH-1:0] inval_cnt = '0;
  logic [COUNT_WIDTH-1:0] outside_cnt = '0;
  logic [COUNT_WIDTH-1:0] seen_cnt = '0;

  out_item_t expected_points[$];
  dir_row_t  dir_rows[$];
  int        err_count = 0;
  int        cycle_count;
  bit        sender_calm = 1'b0;

  point_cloud_crop_feature_encoder u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .in_item   (in_item),
    .empty     (empty),
    .pop       (pop),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [COUNT_WIDTH-1:0] bump(input logic [COUNT_WIDTH-1:0] c);
    return (&c) ? c : c + 1'b1;
  endfunction

  function automatic logic [31:0] clip32(input logic [COUNT_WIDTH-1:0] c);
    logic [63:0] w;
    w = 64'(c);
    return (w > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : w[31:0];
  endfunction

  function automatic bit axis_ok(input logic [47:0] win, input logic signed [23:0] p);
    logic signed [23:0] lo;
    logic signed [23:0] hi;
    lo = win[23:0];
    hi = win[47:24];
    return (p >= lo) && (p < hi);
  endfunction

  // expected result of one point; advances the frame counters
  function automatic out_item_t crop_encode_point(input in_item_t p);
    out_item_t          r;
    logic signed [16:0] d;
    logic [63:0]        q;
    r = '0;
    if (p.frame_start) begin
      inval_cnt   = '0;
      outside_cnt = '0;
      seen_cnt    = '0;
    end
    seen_cnt = bump(seen_cnt);
    if (!p.point_valid || !p.core_finite) begin
      inval_cnt = bump(inval_cnt);
    end else if (!axis_ok(enc_cfg.x_window, p.pos_x) || !axis_ok(enc_cfg.y_window, p.pos_y) ||
                 !axis_ok(enc_cfg.z_window, p.pos_z)) begin
      outside_cnt = bump(outside_cnt);
    end else begin
      r.kept   = 1'b1;
      r.feat_x = p.pos_x;
      r.feat_y = p.pos_y;
      r.feat_z = p.pos_z;
      if (enc_cfg.feature_mode[1]) begin
        r.feat_intensity = p.intensity;
      end else begin
        d = $signed({p.intensity[15], p.intensity}) -
            $signed({enc_cfg.intensity_floor[15], enc_cfg.intensity_floor});
        if (d > 0) begin
          q = (64'(d[15:0]) * 64'(enc_cfg.intensity_recip)) >> 16;
          r.feat_intensity = (q > 64'd32767) ? 16'sd32767 : q[15:0];
        end
      end
      if (enc_cfg.feature_mode[1] && p.elongation_finite)
        r.feat_fifth = p.elongation;
      else if (enc_cfg.feature_mode[0] && p.velocity_finite)
        r.feat_fifth = p.radial_velocity;
    end
    r.invalid_total = clip32(inval_cnt);
    r.outside_total = clip32(outside_cnt);
    r.seen_total    = clip32(seen_cnt);
    return r;
  endfunction

  function automatic in_item_t mk_point(input bit fs, input bit pv, input bit cf,
                                        input logic [23:0] x, input logic [23:0] y,
                                        input logic [23:0] z, input logic [15:0] inten,
                                        input logic [15:0] el, input bit ef,
                                        input logic [15:0] vel, input bit vf);
    in_item_t p;
    p.frame_start       = fs;
    p.point_valid       = pv;
    p.core_finite       = cf;
    p.pos_x             = x;
    p.pos_y             = y;
    p.pos_z             = z;
    p.intensity         = inten;
    p.elongation        = el;
    p.elongation_finite = ef;
    p.radial_velocity   = vel;
    p.velocity_finite   = vf;
    return p;
  endfunction

  function automatic out_item_t mk_result(input bit k, input logic [23:0] x,
                                          input logic [23:0] y, input logic [23:0] z,
                                          input logic [15:0] fi, input logic [15:0] ff,
                                          input logic [31:0] inv, input logic [31:0] outs,
                                          input logic [31:0] seen);
    out_item_t r;
    r.kept           = k;
    r.feat_x         = x;
    r.feat_y         = y;
    r.feat_z         = z;
    r.feat_intensity = fi;
    r.feat_fifth     = ff;
    r.invalid_total  = inv;
    r.outside_total  = outs;
    r.seen_total     = seen;
    return r;
  endfunction

  function automatic logic [47:0] win(input logic [23:0] lo, input logic [23:0] hi);
    return {hi, lo};
  endfunction

  task automatic add_write(input logic [2:0] idx, input logic [47:0] data);
    dir_row_t row;
    row          = '{default: '0};
    row.is_write = 1'b1;
    row.idx      = idx;
    row.data     = data;
    dir_rows.insert(dir_rows.size(), row);
  endtask

  task automatic add_point(input in_item_t pt, input bit typed, input out_item_t res);
    dir_row_t row;
    row       = '{default: '0};
    row.pt    = pt;
    row.typed = typed;
    row.res   = res;
    dir_rows.insert(dir_rows.size(), row);
  endtask

  function automatic int pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // a point: pause, hold push until accepted, then queue its expected result
  task automatic send_point(input in_item_t p, input bit typed, input out_item_t typed_res);
    int        g;
    out_item_t res;
    g = (sender_calm || $urandom_range(0, 2) != 0) ? 0 : pick_len();
    @(negedge clk);
    if (g > 0) begin
      push <= 1'b0;
      repeat (g) @(negedge clk);
    end
    push    <= 1'b1;
    in_item <= p;
    do @(posedge clk); while (full !== 1'b0);
    res = crop_encode_point(p);
    expected_points.insert(expected_points.size(), typed ? typed_res : res);
  endtask

  // hold input until every result is out and the pipeline has settled
  task automatic wait_idle();
    @(negedge clk);
    push <= 1'b0;
    while (expected_points.size() != 0) @(posedge clk);
    repeat (LATENCY + 2) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [47:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    case (idx)
      CFG_X_WINDOW:        enc_cfg.x_window        = data;
      CFG_Y_WINDOW:        enc_cfg.y_window        = data;
      CFG_Z_WINDOW:        enc_cfg.z_window        = data;
      CFG_INTENSITY_FLOOR: enc_cfg.intensity_floor = data[15:0];
      CFG_INTENSITY_RECIP: enc_cfg.intensity_recip = data[31:0];
      CFG_FEATURE_MODE:    enc_cfg.feature_mode    = data[1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [47:0] rand_window();
    int r;
    int lo;
    int hi;
    r = $urandom_range(0, 9);
    if (r == 0) return win(24'h800000, 24'h7FFFFF);
    lo = int'($urandom_range(0, 1 << 21)) - (1 << 20);
    if (r == 1)
      hi = lo - int'($urandom_range(0, 1000));
    else
      hi = lo + int'($urandom_range(1, 1 << 21));
    return win(lo[23:0], hi[23:0]);
  endfunction

  function automatic logic [23:0] axis_pick(input logic [47:0] w);
    int r;
    int lo;
    int hi;
    lo = int'($signed(w[23:0]));
    hi = int'($signed(w[47:24]));
    r  = $urandom_range(0, 99);
    if (r < 80 && lo < hi) return 24'(lo + int'($urandom_range(0, hi - lo - 1)));
    if (r < 85) return 24'(lo);
    if (r < 88) return 24'(hi - 1);
    if (r < 91) return 24'(hi);
    if (r < 93) return 24'(lo - 1);
    return 24'($urandom);
  endfunction

  function automatic in_item_t rand_point();
    in_item_t p;
    p.frame_start = ($urandom_range(0, 49) == 0);
    if ($urandom_range(0, 9) == 0) begin
      p.point_valid = 1'($urandom);
      p.core_finite = 1'($urandom);
    end else begin
      p.point_valid = 1'b1;
      p.core_finite = 1'b1;
    end
    p.pos_x = axis_pick(enc_cfg.x_window);
    p.pos_y = axis_pick(enc_cfg.y_window);
    p.pos_z = axis_pick(enc_cfg.z_window);
    // near the floor often, to hit the zero / small-delta edge
    if ($urandom_range(0, 4) == 0)
      p.intensity = 16'(enc_cfg.intensity_floor + 16'($urandom_range(0, 8)) - 16'd4);
    else
      p.intensity = 16'($urandom);
    p.elongation        = 16'($urandom);
    p.elongation_finite = ($urandom_range(0, 4) != 0);
    p.radial_velocity   = 16'($urandom);
    p.velocity_finite   = ($urandom_range(0, 4) != 0);
    return p;
  endfunction

  task automatic randomize_regs();
    logic [63:0] junk;
    logic [15:0] fl;
    logic [31:0] rc;
    int          r;
    junk = {$urandom, $urandom};
    write_reg(CFG_X_WINDOW, rand_window());
    write_reg(CFG_Y_WINDOW, rand_window());
    write_reg(CFG_Z_WINDOW, rand_window());
    r = $urandom_range(0, 5);
    fl = (r == 0) ? 16'h8000 : (r == 1) ? 16'h7FFF : 16'($urandom);
    write_reg(CFG_INTENSITY_FLOOR, {junk[31:0], fl});
    r = $urandom_range(0, 7);
    if (r == 0) rc = '0;
    else if (r == 1) rc = '1;
    else if (r == 2) rc = $urandom;
    else rc = 32'((64'd32767 << 16) / 64'($urandom_range(1, 65535)));
    write_reg(CFG_INTENSITY_RECIP, {junk[47:32], rc});
    write_reg(CFG_FEATURE_MODE, {junk[45:0], 2'($urandom_range(0, 3))});
  endtask

  task automatic check_field(input string fname, input logic [31:0] e, input logic [31:0] a);
    if (e !== a) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, fname, e, a);
      err_count++;
    end
  endtask

  task automatic check_result(input out_item_t got);
    out_item_t e;
    if (expected_points.size() == 0) begin
      $display("%0t: unexpected item, expected none, got %h", $time, got);
      err_count++;
      return;
    end
    e = expected_points.pop_front();
    check_field("kept", 32'(e.kept), 32'(got.kept));
    check_field("feat_x", 32'(e.feat_x), 32'(got.feat_x));
    check_field("feat_y", 32'(e.feat_y), 32'(got.feat_y));
    check_field("feat_z", 32'(e.feat_z), 32'(got.feat_z));
    check_field("feat_intensity", 32'(e.feat_intensity), 32'(got.feat_intensity));
    check_field("feat_fifth", 32'(e.feat_fifth), 32'(got.feat_fifth));
    check_field("invalid_total", e.invalid_total, got.invalid_total);
    check_field("outside_total", e.outside_total, got.outside_total);
    check_field("seen_total", e.seen_total, got.seen_total);
  endtask

  // result side: random stalls, with calm stretches where pop stays high
  initial begin
    int stall_left;
    int stretch_left;
    bit calm;
    stall_left   = 0;
    stretch_left = 0;
    calm         = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (stretch_left == 0) begin
        calm         = ($urandom_range(0, 3) == 0);
        stretch_left = $urandom_range(100, 500);
      end
      stretch_left--;
      if (stall_left > 0) begin
        pop <= 1'b0;
        stall_left--;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        stall_left = pick_len() - 1;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
      @(posedge clk);
      if (pop && empty === 1'b0) check_result(out_item);
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAIL point_cloud_crop_feature_encoder");
    $finish;
  end

  initial begin
    int        sent;
    int        phase_len;
    dir_row_t  row;
    out_item_t none;
    none = '0;

    // all registers are zero after reset: every window is empty
    add_point(mk_point(1, 0, 1, 0, 0, 0, 0, 0, 0, 0, 0), 1,
              mk_result(0, 0, 0, 0, 0, 0, 1, 0, 1));
    add_point(mk_point(0, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1,
              mk_result(0, 0, 0, 0, 0, 0, 2, 0, 2));
    add_point(mk_point(0, 1, 1, 24'h000010, 0, 0, 0, 0, 0, 0, 0), 1,
              mk_result(0, 0, 0, 0, 0, 0, 2, 1, 3));
    // widest windows, largest reciprocal
    add_write(CFG_X_WINDOW, win(24'h800000, 24'h7FFFFF));
    add_write(CFG_Y_WINDOW, win(24'h800000, 24'h7FFFFF));
    add_write(CFG_Z_WINDOW, win(24'h800000, 24'h7FFFFF));
    add_write(CFG_INTENSITY_FLOOR, 48'h0);
    add_write(CFG_INTENSITY_RECIP, 48'h0000_FFFF_FFFF);
    add_write(CFG_FEATURE_MODE, 48'h0);
    add_point(mk_point(0, 1, 1, 24'h800000, 24'h800000, 24'h800000, 16'h7FFF,
                       16'h1234, 1, 16'h4321, 1), 1,
              mk_result(1, 24'h800000, 24'h800000, 24'h800000, 16'h7FFF, 0, 2, 1, 4));
    // window maximum is exclusive
    add_point(mk_point(0, 1, 1, 24'h7FFFFF, 0, 0, 16'h0100, 0, 1, 0, 1), 1,
              mk_result(0, 0, 0, 0, 0, 0, 2, 2, 5));
    add_point(mk_point(0, 1, 1, 0, 24'h7FFFFE, 24'h7FFFFE, 16'h8000, 0, 1, 0, 1), 0, none);
    add_point(mk_point(0, 1, 1, 24'h000001, 0, 24'hFFFFFF, 16'h0001, 0, 0, 0, 0), 0, none);
    add_point(mk_point(1, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1,
              mk_result(0, 0, 0, 0, 0, 0, 1, 0, 1));
    // junk above the register width is dropped; zero reciprocal
    add_write(CFG_INTENSITY_FLOOR, 48'hFFFF_FFFF_8000);
    add_write(CFG_INTENSITY_RECIP, 48'hFFFF_0000_0000);
    add_write(CFG_FEATURE_MODE, 48'hFFFF_FFFF_FFFD);
    add_point(mk_point(0, 1, 1, 24'h123456, 24'hABCDEF, 0, 16'h7FFF, 16'h5555, 1,
                       16'h8000, 1), 0, none);
    add_point(mk_point(0, 1, 1, 0, 0, 0, 16'h0000, 0, 1, 16'h7FFF, 0), 0, none);
    // raw intensity with elongation, falling back to velocity
    add_write(CFG_FEATURE_MODE, 48'h3);
    add_write(CFG_INTENSITY_RECIP, 48'h0001_0000);
    add_point(mk_point(0, 1, 1, 0, 0, 0, 16'h8000, 16'h7FFF, 1, 16'h1111, 1), 0, none);
    add_point(mk_point(0, 1, 1, 0, 0, 0, 16'h7FFF, 16'h8000, 0, 16'h8000, 1), 0, none);
    add_point(mk_point(0, 1, 1, 0, 0, 0, 16'h0042, 16'h2222, 0, 16'h3333, 0), 0, none);
    add_write(CFG_FEATURE_MODE, 48'h2);
    add_point(mk_point(0, 1, 1, 0, 0, 0, 16'hFF00, 16'h2222, 0, 16'h3333, 1), 0, none);
    // floor at its top: nothing lies above it
    add_write(CFG_FEATURE_MODE, 48'h0);
    add_write(CFG_INTENSITY_FLOOR, 48'h7FFF);
    add_point(mk_point(0, 1, 1, 0, 0, 0, 16'h7FFF, 0, 0, 16'h0101, 1), 0, none);
    add_point(mk_point(0, 1, 1, 0, 0, 0, 16'h8000, 0, 0, 0, 0), 0, none);
    // narrow x window, y window with minimum above maximum
    add_write(CFG_X_WINDOW, win(24'hFFFF00, 24'h000100));
    add_write(CFG_Y_WINDOW, win(24'h000100, 24'hFFFF00));
    add_point(mk_point(0, 1, 1, 24'hFFFF00, 0, 0, 0, 0, 0, 0, 0), 0, none);
    add_write(CFG_Y_WINDOW, win(24'hFFFF00, 24'h000100));
    add_point(mk_point(0, 1, 1, 24'hFFFF00, 24'h0000FF, 0, 16'h7FFF, 0, 0, 0, 0), 0, none);
    add_point(mk_point(0, 1, 1, 24'hFFFEFF, 0, 0, 0, 0, 0, 0, 0), 0, none);
    add_point(mk_point(0, 1, 1, 24'h000100, 0, 0, 0, 0, 0, 0, 0), 0, none);
    add_write(CFG_IDX_UNUSED, 48'hFFFF_FFFF_FFFF);
    add_point(mk_point(0, 1, 1, 24'hFFFF00, 24'h0000FF, 0, 16'h7FFF, 0, 0, 0, 0), 0, none);
    add_point(mk_point(1, 0, 0, 24'h7FFFFF, 24'h800000, 24'h000000, 16'hFFFF, 16'hFFFF, 1,
                       16'hFFFF, 1), 0, none);

    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      if (row.is_write) begin
        wait_idle();
        write_reg(row.idx, row.data);
      end else begin
        send_point(row.pt, row.typed, row.res);
      end
    end

    // random phases; each starts from an idle block with fresh registers
    sent = 0;
    while (sent < RAND_POINTS) begin
      wait_idle();
      randomize_regs();
      sender_calm = ($urandom_range(0, 3) == 0);
      phase_len   = $urandom_range(60, 250);
      repeat (phase_len) begin
        send_point(rand_point(), 0, none);
        sent++;
      end
    end

    wait_idle();
    if (err_count == 0)
      $display("PASS point_cloud_crop_feature_encoder");
    else
      $display("FAIL point_cloud_crop_feature_encoder");
    $finish;
  end

endmodule
